// ===== rtl/core/ssrr_pkg.sv =====
`default_nettype none
package ssrr_pkg;

  localparam int FRACTION_BITS = 8;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_NUM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A2D_RATIO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_D2A_RATIO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WATCH_JERK = 3'd5;

  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_END_BRK  = 3'd1;
  localparam logic [2:0] ACT_JERK_BRK = 3'd2;
  localparam logic [2:0] ACT_TARGET   = 3'd3;
  localparam logic [2:0] ACT_ACCEL    = 3'd4;
  localparam logic [2:0] ACT_DECEL    = 3'd5;
  localparam logic [2:0] ACT_START    = 3'd6;

  // shared divider request and reply
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  // shared root unit request and reply
  typedef struct packed {
    logic        start;
    logic [31:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] root;
  } sqrt_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/stepper_speed_ramp_regulator.sv =====
`default_nettype none
// channel | direction | ports
// in      | input     | in_valid, in_ready, in_kind, in_end_distance, in_jerk_distance,
//         |           | in_start_period
// out     | output    | out_valid, out_ready, out_period, out_period_changed, out_action
// cfg     | input     | cfg_we, cfg_idx, cfg_data
//
// one word at a time: a start or a tick with no update goes from decide straight to output;
// a ramp or brake tick takes a 32x24 ratio multiply, a 16-step root and a 32-step divider,
// target reached a 32-step divider, a squaring, a ratio multiply and a 16-step root
// the shared divider and root unit each give one bit per cycle
// synchronous active-low reset restores the register defaults and motion state
// input is not ready while a word is in work or its result waits in the output register
module stepper_speed_ramp_regulator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_kind,
  input  wire logic [23:0] in_end_distance,
  input  wire logic [23:0] in_jerk_distance,
  input  wire logic [31:0] in_start_period,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_period,
  output logic             out_period_changed,
  output logic [2:0]       out_action,
  input  wire logic        cfg_we,
  input  wire logic [ssrr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [ssrr_pkg::CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECIDE = 9'b000000010,
    S_TDIV   = 9'b000000100,
    S_TSQ    = 9'b000001000,
    S_SCALE  = 9'b000010000,
    S_ROOT   = 9'b000100000,
    S_PDIV   = 9'b001000000,
    S_DONE   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [31:0] dnum_r, tgt_r, step_r;
  logic [23:0] a2d_r, d2a_r;
  logic        watch_r;

  // motion state
  logic [31:0] accel_r, accel_nxt;
  logic [31:0] brake_r, brake_nxt;
  logic [15:0] root_r, root_nxt;
  logic [31:0] per_r, per_nxt;
  logic        rising_r, rising_nxt;
  logic        reg_on_r, reg_on_nxt;
  logic        skip_r, skip_nxt;

  // captured word and job flags
  logic        kind_r;
  logic [23:0] endd_r, jerkd_r;
  logic [31:0] sp_r;
  logic        chg_r, chg_nxt;
  logic [2:0]  act_r, act_nxt;
  logic        brk_r, brk_nxt;   // brake: scale brake into accel
  logic        pend_r, pend_nxt; // period recompute pending after root

  // registered product stage
  logic [55:0] prod_r;
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [31:0] scaled;

  ssrr_pkg::div_req_t  dreq;
  ssrr_pkg::div_rsp_t  drsp;
  ssrr_pkg::sqrt_req_t sreq;
  ssrr_pkg::sqrt_rsp_t srsp;

  ssrr_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
  ssrr_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sreq), .rsp(srsp));

  logic [40:0] end_sh, jerk_sh;
  logic [32:0] sum33;
  logic        end_hit, jerk_hit, too_slow;
  logic [31:0] tq;
  logic [15:0] tr;
  logic [55:0] shifted;
  logic [55:0] sq_sh;

  assign end_sh    = {17'd0, endd_r} << ssrr_pkg::FRACTION_BITS;
  assign jerk_sh   = {17'd0, jerkd_r} << ssrr_pkg::FRACTION_BITS;
  assign end_hit   = end_sh < {9'd0, brake_r};
  assign jerk_hit  = watch_r && (jerk_sh < {9'd0, brake_r});
  assign too_slow  = per_r > tgt_r;
  assign sum33     = {1'b0, accel_r} + {1'b0, step_r};
  assign tq        = (tgt_r == 32'd0) ? 32'hFFFF_FFFF : drsp.quotient;
  assign tr        = (tq > 32'd65535) ? 16'hFFFF : tq[15:0];
  assign shifted   = prod_r >> 16;
  assign scaled    = (shifted[55:32] != 24'd0) ? 32'hFFFF_FFFF : shifted[31:0];
  assign sq_sh     = prod_r << ssrr_pkg::FRACTION_BITS;

  // multiplier operands, product registered before use
  always_comb begin
    mul_a = brk_r ? brake_r : accel_r;
    mul_b = brk_r ? d2a_r : a2d_r;
  end

  always_comb begin
    state_nxt  = state_r;
    accel_nxt  = accel_r;
    brake_nxt  = brake_r;
    root_nxt   = root_r;
    per_nxt    = per_r;
    rising_nxt = rising_r;
    reg_on_nxt = reg_on_r;
    skip_nxt   = skip_r;
    chg_nxt    = chg_r;
    act_nxt    = act_r;
    brk_nxt    = brk_r;
    pend_nxt   = pend_r;
    dreq       = '0;
    sreq       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        chg_nxt  = 1'b0;
        act_nxt  = ssrr_pkg::ACT_NONE;
        brk_nxt  = 1'b0;
        pend_nxt = 1'b1;
        state_nxt = S_OUT;
        if (kind_r) begin
          per_nxt    = (sp_r > tgt_r) ? sp_r : tgt_r;
          rising_nxt = 1'b1;
          reg_on_nxt = 1'b1;
          skip_nxt   = 1'b0;
          chg_nxt    = 1'b1;
          act_nxt    = ssrr_pkg::ACT_START;
        end else if (end_hit || jerk_hit) begin
          brake_nxt  = end_hit ? ((end_sh[40:32] != 9'd0) ? 32'hFFFF_FFFF : end_sh[31:0])
                               : ((jerk_sh[40:32] != 9'd0) ? 32'hFFFF_FFFF : jerk_sh[31:0]);
          brk_nxt    = 1'b1;
          reg_on_nxt = 1'b1;
          rising_nxt = 1'b1;
          skip_nxt   = 1'b1;
          chg_nxt    = 1'b1;
          act_nxt    = end_hit ? ssrr_pkg::ACT_END_BRK : ssrr_pkg::ACT_JERK_BRK;
          state_nxt  = S_SCALE;
        end else if (reg_on_r) begin
          if (skip_r) begin
            skip_nxt = 1'b0;
          end else if (too_slow != rising_r) begin
            per_nxt       = tgt_r;
            dreq.start    = 1'b1;
            dreq.dividend = dnum_r;
            dreq.divisor  = tgt_r;
            reg_on_nxt    = 1'b0;
            pend_nxt      = 1'b0;
            act_nxt       = ssrr_pkg::ACT_TARGET;
            state_nxt     = S_TDIV;
          end else if (too_slow) begin
            accel_nxt  = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
            rising_nxt = 1'b1;
            chg_nxt    = 1'b1;
            act_nxt    = ssrr_pkg::ACT_ACCEL;
            state_nxt  = S_SCALE;
          end else begin
            accel_nxt  = (accel_r > step_r) ? accel_r - step_r : 32'd0;
            rising_nxt = 1'b0;
            chg_nxt    = 1'b1;
            act_nxt    = ssrr_pkg::ACT_DECEL;
            state_nxt  = S_SCALE;
          end
        end
      end
      S_TDIV: begin
        if (drsp.done) begin
          root_nxt  = tr;
          state_nxt = S_TSQ;
        end
      end
      S_TSQ: begin
        // product of root with itself, shifted and saturated
        if (sq_sh[55:32] != 24'd0) accel_nxt = 32'hFFFF_FFFF;
        else accel_nxt = sq_sh[31:0];
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        // product register loads from the current operands here, for use in the root state
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (brk_r) accel_nxt = scaled;
        else brake_nxt = scaled;
        brk_nxt   = 1'b0;
        sreq.start    = 1'b1;
        sreq.radicand = (brk_r ? scaled : accel_r) >> ssrr_pkg::FRACTION_BITS;
        state_nxt = S_PDIV;
      end
      S_PDIV: begin
        if (srsp.done) begin
          root_nxt = srsp.root;
          if (pend_r && srsp.root != 16'd0) begin
            dreq.start    = 1'b1;
            dreq.dividend = dnum_r;
            dreq.divisor  = {16'd0, srsp.root};
            state_nxt     = S_DONE;
          end else begin
            if (pend_r) per_nxt = 32'd0;
            state_nxt = S_OUT;
          end
        end
      end
      S_DONE: begin
        if (drsp.done) begin
          per_nxt   = drsp.quotient;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // squaring of the target root shares the product register
  always_ff @(posedge clk) begin
    if (state_r == S_TDIV) prod_r <= {24'd0, tr} * {24'd0, tr};
    else prod_r <= mul_a * {32'd0, mul_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      dnum_r   <= '0;
      tgt_r    <= '0;
      a2d_r    <= 24'd65536;
      d2a_r    <= 24'd65536;
      step_r   <= '0;
      watch_r  <= 1'b0;
      accel_r  <= '0;
      brake_r  <= '0;
      root_r   <= '0;
      per_r    <= '0;
      rising_r <= 1'b1;
      reg_on_r <= 1'b1;
      skip_r   <= 1'b0;
      chg_r    <= 1'b0;
      act_r    <= ssrr_pkg::ACT_NONE;
      brk_r    <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      accel_r  <= accel_nxt;
      brake_r  <= brake_nxt;
      root_r   <= root_nxt;
      per_r    <= per_nxt;
      rising_r <= rising_nxt;
      reg_on_r <= reg_on_nxt;
      skip_r   <= skip_nxt;
      chg_r    <= chg_nxt;
      act_r    <= act_nxt;
      brk_r    <= brk_nxt;
      pend_r   <= pend_nxt;
      // register writes
      if (cfg_we) begin
        case (cfg_idx)
          ssrr_pkg::REG_DELAY_NUM:  dnum_r  <= cfg_data;
          ssrr_pkg::REG_TARGET:     tgt_r   <= cfg_data;
          ssrr_pkg::REG_A2D_RATIO:  a2d_r   <= cfg_data[23:0];
          ssrr_pkg::REG_D2A_RATIO:  d2a_r   <= cfg_data[23:0];
          ssrr_pkg::REG_RAMP_STEP:  step_r  <= cfg_data;
          ssrr_pkg::REG_WATCH_JERK: watch_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // capture the input word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r  <= in_kind;
      endd_r  <= in_end_distance;
      jerkd_r <= in_jerk_distance;
      sp_r    <= in_start_period;
    end
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = (state_r == S_OUT);
  assign out_period         = per_r;
  assign out_period_changed = chg_r;
  assign out_action         = act_r;

endmodule
`default_nettype wire

// ===== rtl/core/ssrr_div.sv =====
`default_nettype none
// restoring divider, one quotient bit per cycle
module ssrr_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ssrr_pkg::div_req_t req,
  output ssrr_pkg::div_rsp_t      rsp
);

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [32:0] shifted;

  // one shift and subtract step
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[31]};
    trial    = shifted - {1'b0, dvs_r};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/core/ssrr_sqrt.sv =====
`default_nettype none
// digit-by-digit integer root, one result bit per cycle
module ssrr_sqrt (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ssrr_pkg::sqrt_req_t req,
  output ssrr_pkg::sqrt_rsp_t      rsp
);

  logic [31:0] val_r, val_nxt;
  logic [31:0] res_r, res_nxt;
  logic [31:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] sum;

  always_comb begin
    val_nxt  = val_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sum      = {1'b0, res_r} + {1'b0, bit_r};
    if (req.start) begin
      val_nxt  = req.radicand;
      res_nxt  = '0;
      bit_nxt  = 32'h4000_0000;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ({1'b0, val_r} >= sum) begin
        val_nxt = val_r - sum[31:0];
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == 32'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    val_r <= val_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  // root of a 32-bit value never exceeds 65535
  assign rsp.done = done_r;
  assign rsp.root = res_r[15:0];

endmodule
`default_nettype wire

// ===== bench/stepper_speed_ramp_regulator_test.sv =====
`default_nettype none
module stepper_speed_ramp_regulator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ssrr_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [23:0] end_dist;
    logic [23:0] jerk_dist;
    logic [31:0] start_per;
  } move_word_t;

  typedef struct packed {
    logic [31:0] period;
    logic        changed;
    logic [2:0]  action;
  } speed_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [23:0] in_end_distance = '0;
  logic [23:0] in_jerk_distance = '0;
  logic [31:0] in_start_period = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_period;
  logic out_period_changed;
  logic [2:0] out_action;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  stepper_speed_ramp_regulator dut (.*);

  always #6 clk = ~clk;

  // predictor copy of registers and motion state
  logic [31:0] p_numer, p_target, p_step;
  logic [23:0] p_a2d, p_d2a;
  logic        p_watch;
  logic [31:0] p_accel, p_brake, p_period;
  logic [15:0] p_root;
  logic        p_rising, p_reg_on, p_skip;

  move_word_t  pending_moves[$];
  speed_word_t expected_speeds[$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 0;
  bit pause_send = 0;

  function automatic logic [31:0] sat_to_32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] apply_ratio(logic [31:0] d, logic [23:0] r);
    logic [63:0] prod;
    prod = {32'd0, d} * {40'd0, r};
    return sat_to_32(prod >> 16);
  endfunction

  function automatic logic [15:0] int_root(logic [31:0] v);
    logic [31:0] lo, hi, mid;
    lo = 0;
    hi = 65535;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if ({32'd0, mid} * {32'd0, mid} <= {32'd0, v}) lo = mid;
      else hi = mid - 1;
    end
    return lo[15:0];
  endfunction

  function automatic void set_root_from_accel();
    p_brake = apply_ratio(p_accel, p_a2d);
    p_root = int_root(p_accel >> FRACTION_BITS);
  endfunction

  function automatic void period_from_root();
    p_period = (p_root == 16'd0) ? 32'd0 : p_numer / {16'd0, p_root};
  endfunction

  function automatic void brake_toward(logic [23:0] steps);
    p_brake = sat_to_32({40'd0, steps} << FRACTION_BITS);
    p_accel = apply_ratio(p_brake, p_d2a);
    p_root = int_root(p_accel >> FRACTION_BITS);
    period_from_root();
    p_reg_on = 1'b1;
    p_rising = 1'b1;
    p_skip = 1'b1;
  endfunction

  // work out the expected speed word for one move word
  function automatic speed_word_t predict_speed(move_word_t w);
    speed_word_t s;
    logic [31:0] r;
    logic        slow;
    s.changed = 1'b0;
    s.action = ACT_NONE;
    if (w.kind) begin
      p_period = (w.start_per > p_target) ? w.start_per : p_target;
      p_rising = 1'b1; p_reg_on = 1'b1; p_skip = 1'b0;
      s.changed = 1'b1; s.action = ACT_START;
    end else if (({40'd0, w.end_dist} << FRACTION_BITS) < {32'd0, p_brake}) begin
      brake_toward(w.end_dist);
      s.changed = 1'b1; s.action = ACT_END_BRK;
    end else if (p_watch && (({40'd0, w.jerk_dist} << FRACTION_BITS) < {32'd0, p_brake}))
    begin
      brake_toward(w.jerk_dist);
      s.changed = 1'b1; s.action = ACT_JERK_BRK;
    end else if (p_reg_on) begin
      if (p_skip) begin
        p_skip = 1'b0;
      end else begin
        slow = p_period > p_target;
        if (slow != p_rising) begin
          p_period = p_target;
          r = (p_target == 0) ? 32'd65535 : p_numer / p_target;
          if (r > 65535) r = 65535;
          p_accel = sat_to_32(({32'd0, r} * {32'd0, r}) << FRACTION_BITS);
          set_root_from_accel();
          p_reg_on = 1'b0;
          s.action = ACT_TARGET;
        end else if (slow) begin
          p_accel = sat_to_32({32'd0, p_accel} + {32'd0, p_step});
          set_root_from_accel();
          period_from_root();
          p_rising = 1'b1;
          s.changed = 1'b1; s.action = ACT_ACCEL;
        end else begin
          p_accel = (p_accel > p_step) ? p_accel - p_step : 32'd0;
          set_root_from_accel();
          period_from_root();
          p_rising = 1'b0;
          s.changed = 1'b1; s.action = ACT_DECEL;
        end
      end
    end
    s.period = p_period;
    return s;
  endfunction

  // acceptance seen at the rising edge
  logic in_ready_seen = 1'b0;
  always @(posedge clk) in_ready_seen <= in_valid && in_ready;

  // driver: bursts and gaps, updates at the falling edge
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (in_valid && in_ready_seen) begin
      // word taken at the last rising edge
    end
    if (!in_valid || in_ready_seen) begin
      if (rst_n && !pause_send && pending_moves.size() != 0 && gap_left == 0) begin
        move_word_t w;
        w = pending_moves.pop_front();
        in_valid <= 1'b1;
        in_kind <= w.kind;
        in_end_distance <= w.end_dist;
        in_jerk_distance <= w.jerk_dist;
        in_start_period <= w.start_per;
        expected_queue_push(w);
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // the prediction is made when a word is put on the bus; words go in order
  task automatic expected_queue_push(move_word_t w);
    expected_speeds.push_back(predict_speed(w));
  endtask

  // receiver stall pattern
  logic [7:0] stall_pat = 8'b1011_0110;
  always @(negedge clk) begin
    stall_pat <= {stall_pat[6:0], stall_pat[7] ^ stall_pat[5] ^ ($urandom_range(0, 3) == 0)};
    out_ready <= (cycles % 400 < 100) ? 1'b1 : stall_pat[0];
  end

  // monitor: compare each accepted speed word with the oldest expectation
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (expected_speeds.size() == 0) begin
        $display("%t: unexpected speed word period %h action %0d", $time, out_period,
                 out_action);
        errors++;
      end else begin
        speed_word_t e;
        e = expected_speeds.pop_front();
        if (out_period !== e.period) begin
          $display("%t: period expected %h actual %h", $time, e.period, out_period);
          errors++;
        end
        if (out_period_changed !== e.changed) begin
          $display("%t: changed expected %b actual %b", $time, e.changed, out_period_changed);
          errors++;
        end
        if (out_action !== e.action) begin
          $display("%t: action expected %0d actual %0d", $time, e.action, out_action);
          errors++;
        end
      end
    end
    if (cycles > 900000) begin
      $display("stepper_speed_ramp_regulator test failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DELAY_NUM:  p_numer = val;
      REG_TARGET:     p_target = val;
      REG_A2D_RATIO:  p_a2d = val[23:0];
      REG_D2A_RATIO:  p_d2a = val[23:0];
      REG_RAMP_STEP:  p_step = val;
      REG_WATCH_JERK: p_watch = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_moves.size() != 0 || expected_speeds.size() != 0 || in_valid)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic move_word_t mk(logic k, logic [23:0] e, logic [23:0] j, logic [31:0] s);
    move_word_t w;
    w.kind = k; w.end_dist = e; w.jerk_dist = j; w.start_per = s;
    return w;
  endfunction

  // one random move: start, then ticks with mostly falling distances and an occasional random word
  task automatic queue_move(int ticks);
    logic [23:0] e, j;
    e = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 4000));
    j = ($urandom_range(0, 2) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 2000));
    pending_moves.push_back(mk(1'b1, 24'($urandom()), 24'($urandom()),
      $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 20000)));
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        pending_moves.push_back(mk(1'($urandom_range(0, 1)), 24'($urandom()),
                                   24'($urandom()), $urandom()));
      end else begin
        pending_moves.push_back(mk(1'b0, e, j, $urandom()));
        e = (e > 24'd20) ? e - 24'($urandom_range(0, 20)) : 24'd0;
        j = (j > 24'd30) ? j - 24'($urandom_range(0, 30)) : 24'($urandom_range(0, 3000));
      end
    end
  endtask

  task automatic random_config(bit extreme);
    write_reg(REG_DELAY_NUM, extreme ? 32'hFFFF_FFFF : $urandom_range(1000, 2000000));
    write_reg(REG_TARGET, extreme ? ($urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF)
                                  : $urandom_range(0, 2000));
    write_reg(REG_A2D_RATIO, extreme ? 32'hFF_FFFF : $urandom_range(16384, 200000));
    write_reg(REG_D2A_RATIO, extreme ? 32'd0 : $urandom_range(16384, 200000));
    write_reg(REG_RAMP_STEP, extreme ? 32'hFFFF_FFFF : $urandom_range(0, 1 << 16));
    write_reg(REG_WATCH_JERK, $urandom_range(0, 1));
  endtask

  initial begin
    p_numer = 0; p_target = 0; p_a2d = 24'd65536; p_d2a = 24'd65536;
    p_step = 0; p_watch = 1'b0;
    p_accel = 0; p_brake = 0; p_root = 0; p_period = 0;
    p_rising = 1'b1; p_reg_on = 1'b1; p_skip = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: defaults first, zero root and clamps
    pending_moves.push_back(mk(1'b0, 24'd0, 24'd0, 32'd0));
    pending_moves.push_back(mk(1'b1, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF));
    pending_moves.push_back(mk(1'b0, 24'hFFFFFF, 24'hFFFFFF, 32'd0));
    wait_idle();
    write_reg(REG_DELAY_NUM, 32'd1000000);
    write_reg(REG_TARGET, 32'd500);
    write_reg(REG_RAMP_STEP, 32'd4096);
    write_reg(REG_WATCH_JERK, 32'd1);
    write_reg(3'd7, 32'h1234_5678);
    pending_moves.push_back(mk(1'b1, 24'd0, 24'd0, 32'd100000));
    for (int i = 0; i < 8; i++)
      pending_moves.push_back(mk(1'b0, 24'hFFFFFF, 24'hFFFFFF, 32'd0));
    pending_moves.push_back(mk(1'b0, 24'hFFFFFF, 24'd1, 32'd0));
    pending_moves.push_back(mk(1'b0, 24'hFFFFFF, 24'hFFFFFF, 32'd0));
    pending_moves.push_back(mk(1'b0, 24'd0, 24'hFFFFFF, 32'd0));
    pending_moves.push_back(mk(1'b0, 24'hFFFFFF, 24'hFFFFFF, 32'd0));
    pending_moves.push_back(mk(1'b1, 24'd0, 24'd0, 32'd0));
    for (int i = 0; i < 6; i++)
      pending_moves.push_back(mk(1'b0, 24'hFFFFFF, 24'hFFFFFF, 32'd0));
    wait_idle();

    // random phases, extremes among them
    for (int ph = 0; ph < 8; ph++) begin
      random_config(ph == 3 || ph == 7);
      while (pending_moves.size() < 90) queue_move($urandom_range(5, 40));
      if (ph == 5) begin
        while (pending_moves.size() > 45) @(posedge clk);
        pause_send = 1;
        while (expected_speeds.size() != 0 || in_valid) @(posedge clk);
        pause_send = 0;
      end
      wait_idle();
    end
    stim_done = 1;
    wait_idle();
    if (errors == 0) begin
      $display("stepper_speed_ramp_regulator test passed");
    end else begin
      $display("stepper_speed_ramp_regulator test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/ssrr_pkg.sv
rtl/core/ssrr_div.sv
rtl/core/ssrr_sqrt.sv
rtl/core/stepper_speed_ramp_regulator.sv
bench/stepper_speed_ramp_regulator_test.sv
